// ===== rtl/midi_voice_arpeggiator_core_macros.svh =====
// ----------------------------------------------------------------------------
// midi_voice_arpeggiator_core assertion macros
// Shared property templates for the arpeggiator RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_VOICE_ARPEGGIATOR_CORE_MACROS_SVH
`define MIDI_VOICE_ARPEGGIATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MVA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Types, constants and small tables shared by the arpeggiator modules.
// ----------------------------------------------------------------------------
package mva_pkg;

    // MIDI codes
    localparam logic [7:0] KEY_FREE      = 8'hFF;
    localparam logic [6:0] KEY_LOWEST    = 7'd14;
    localparam logic [6:0] KEY_A4        = 7'd69;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
    localparam logic [3:0] DRUM_CHANNEL  = 4'd9;

    // Speaker action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SILENCE = 2'd1;
    localparam logic [1:0] ACT_BEEP    = 2'd2;

    // Pitch arithmetic (u32f8)
    localparam logic [12:0] FREQ_A4       = 13'd440;
    localparam logic [24:0] FREQ_A4_SHL16 = 25'd28835840;
    localparam logic [31:0] INPUT_RATE    = 32'd305454507;
    localparam logic [15:0] DIVISOR_MAX   = 16'hFFFF;

    localparam logic [15:0] SWEEP_RESET = 16'd16;

    // Shared divider
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic       start;
        logic [6:0] key;
    } t_pitch_req;

    typedef struct packed {
        logic        done;
        logic [15:0] divisor;
    } t_pitch_rsp;

    typedef struct packed {
        logic [2:0] oct;
        logic [3:0] semi;
    } t_oct_split;

    // 256 + semitone fraction, factor (1 + m/256) per semitone
    function automatic logic [8:0] semitone_mult(input logic [3:0] idx);
        logic [8:0] m;
        case (idx)
            4'd0:    m = 9'd256;
            4'd1:    m = 9'd271;
            4'd2:    m = 9'd287;
            4'd3:    m = 9'd304;
            4'd4:    m = 9'd323;
            4'd5:    m = 9'd342;
            4'd6:    m = 9'd362;
            4'd7:    m = 9'd384;
            4'd8:    m = 9'd406;
            4'd9:    m = 9'd431;
            4'd10:   m = 9'd456;
            4'd11:   m = 9'd483;
            default: m = 9'd256;
        endcase
        return m;
    endfunction

    // Split a semitone distance into octaves and remaining semitones
    function automatic t_oct_split split12(input logic [5:0] d);
        logic [5:0]  r;
        logic [2:0]  o;
        t_oct_split  res;
        r = d;
        o = '0;
        for (int k = 0; k < 5; k++) begin
            if (r >= 6'd12) begin
                r = r - 6'd12;
                o = o + 3'd1;
            end
        end
        res.oct  = o;
        res.semi = r[3:0];
        return res;
    endfunction

endpackage

// ===== rtl/mva_divider.sv =====
// ----------------------------------------------------------------------------
// mva_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mva_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mva_pkg::t_div_req i_req,
    output mva_pkg::t_div_rsp o_rsp
);
    import mva_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_den;

    logic [DIV_W:0]       w_shift;
    logic [DIV_W+1:0]     w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = !w_diff[DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/mva_pitch.sv =====
// ----------------------------------------------------------------------------
// mva_pitch
// Sequencer that turns a MIDI key into a timer divisor via the shared divider.
// ----------------------------------------------------------------------------
module mva_pitch (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mva_pkg::t_pitch_req i_req,
    output mva_pkg::t_pitch_rsp o_rsp,
    output mva_pkg::t_div_req   o_div_req,
    input  mva_pkg::t_div_rsp   i_div_rsp
);
    import mva_pkg::*;

    localparam logic [2:0] P_IDLE   = 3'd0;
    localparam logic [2:0] P_SCALE  = 3'd1;
    localparam logic [2:0] P_FDIV   = 3'd2;
    localparam logic [2:0] P_QSTART = 3'd3;
    localparam logic [2:0] P_QWAIT  = 3'd4;

    logic [2:0]  r_state;
    logic        r_done;
    logic        r_up;
    logic [2:0]  r_oct;
    logic [8:0]  r_mult;
    logic [31:0] r_freq;
    logic [15:0] r_result;

    logic [6:0]  w_dist;
    t_oct_split  w_split;
    logic [12:0] w_up_base;
    logic [21:0] w_up_freq;
    logic [24:0] w_dn_base;

    assign w_dist    = (i_req.key > KEY_A4) ? (i_req.key - KEY_A4) : (KEY_A4 - i_req.key);
    assign w_split   = split12(w_dist[5:0]);
    assign w_up_base = FREQ_A4 << r_oct;
    assign w_up_freq = 22'(w_up_base) * 22'(r_mult);
    assign w_dn_base = FREQ_A4_SHL16 >> r_oct;

    // Divider operands: semitone scaling first on the downward path, then the rate
    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = INPUT_RATE;
        o_div_req.divisor  = r_freq;
        if (r_state == P_SCALE && !r_up) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = {7'b0, w_dn_base};
            o_div_req.divisor  = {23'b0, r_mult};
        end else if (r_state == P_QSTART && r_freq != '0) begin
            o_div_req.start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                P_IDLE: begin
                    if (i_req.start) begin
                        r_state <= P_SCALE;
                    end
                end
                P_SCALE: begin
                    r_state <= r_up ? P_QSTART : P_FDIV;
                end
                P_FDIV: begin
                    if (i_div_rsp.done) begin
                        r_state <= P_QSTART;
                    end
                end
                P_QSTART: begin
                    if (r_freq == '0) begin
                        r_done  <= 1'b1;
                        r_state <= P_IDLE;
                    end else begin
                        r_state <= P_QWAIT;
                    end
                end
                P_QWAIT: begin
                    if (i_div_rsp.done) begin
                        r_done  <= 1'b1;
                        r_state <= P_IDLE;
                    end
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == P_IDLE && i_req.start) begin
            r_up   <= i_req.key > KEY_A4;
            r_oct  <= w_split.oct;
            r_mult <= semitone_mult(w_split.semi);
        end
        if (r_state == P_SCALE && r_up) begin
            r_freq <= {10'b0, w_up_freq};
        end
        if (r_state == P_FDIV && i_div_rsp.done) begin
            r_freq <= i_div_rsp.quotient;
        end
        if (r_state == P_QSTART && r_freq == '0) begin
            r_result <= DIVISOR_MAX;
        end
        if (r_state == P_QWAIT && i_div_rsp.done) begin
            // saturate to the timer width
            r_result <= (i_div_rsp.quotient[31:16] != '0) ? DIVISOR_MAX
                                                          : i_div_rsp.quotient[15:0];
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.divisor = r_result;

endmodule

// ===== rtl/midi_voice_arpeggiator_core.sv =====
// ----------------------------------------------------------------------------
// midi_voice_arpeggiator_core
// Voice slot manager and round-robin arpeggiator for a square-wave speaker.
//
//   Channel   Direction  Transaction contents
//   s_axis    in         tuser: op; tdata: status, key, velocity, timestamp
//   m_axis    out        tuser: accepted, speaker action; tdata: timer divisor
//   cfg       in         write enable + 16-bit sweep interval, no read-back
//
// A tick, or any event that claims no slot, passes through the decode and
// output states from accept to result transaction.
// A note-on that claims a slot runs the pitch sequencer on the shared 32-step
// divider: one division for keys above A4, two for A4 and below.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next transaction is accepted.
// Reset is synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
`include "midi_voice_arpeggiator_core_macros.svh"

module midi_voice_arpeggiator_core #(
    parameter int VOICE_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // status_byte, note_key, note_velocity, timestamp
    input  logic        i_s_axis_tuser,  // op
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // pit_divisor
    output logic [2:0]  o_m_axis_tuser,  // accepted, speaker_action
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import mva_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int IW = VW + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_PITCH  = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    // control state
    logic [1:0]  r_state, n_state;
    logic [7:0]  r_slot_key [VOICE_COUNT];
    logic [7:0]  n_slot_key [VOICE_COUNT];
    logic [15:0] r_slot_div [VOICE_COUNT];
    logic [15:0] n_slot_div [VOICE_COUNT];
    logic [VW-1:0] r_cur, n_cur;
    logic [31:0] r_last, n_last;
    logic [15:0] r_sweep;
    logic        r_out_valid, n_out_valid;

    // transaction payload
    logic        r_op;
    logic [7:0]  r_status;
    logic [7:0]  r_key;
    logic [7:0]  r_vel;
    logic [31:0] r_ts;
    logic [VW-1:0] r_slot_sel, n_slot_sel;
    logic        r_res_acc, n_res_acc;
    logic [1:0]  r_res_act, n_res_act;
    logic [15:0] r_res_div, n_res_div;
    logic        r_out_acc, n_out_acc;
    logic [1:0]  r_out_act, n_out_act;
    logic [15:0] r_out_div, n_out_div;

    t_pitch_req w_pitch_req;
    t_pitch_rsp w_pitch_rsp;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    logic          w_s_fire;
    logic [3:0]    w_type;
    logic [3:0]    w_chan;
    logic          w_chan_skip;
    logic          w_is_note;
    logic          w_bad_data;
    logic          w_is_off;
    logic          w_match_found;
    logic [VW-1:0] w_match_idx;
    logic          w_free_found;
    logic [VW-1:0] w_free_idx;
    logic          w_any_held;
    logic [31:0]   w_elapsed;
    logic [VW-1:0] w_cur_eff;
    logic [VW-1:0] w_next_idx;
    logic          w_note_on_go;

    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // ---- event decode --------------------------------------------------------
    assign w_type      = r_status[7:4];
    // system messages count as channel 0
    assign w_chan      = (w_type == TYPE_SYSTEM) ? 4'd0 : r_status[3:0];
    assign w_chan_skip = ({1'b0, w_chan} >= 5'(VOICE_COUNT)) || (w_chan == DRUM_CHANNEL);
    assign w_is_note   = (w_type == TYPE_NOTE_OFF) || (w_type == TYPE_NOTE_ON);
    assign w_bad_data  = r_key[7] || r_vel[7];
    assign w_is_off    = (w_type == TYPE_NOTE_OFF) || (r_vel == 8'd0);

    // ---- slot searches: first match, first free, any held ----------------------
    always_comb begin
        w_match_found = 1'b0;
        w_match_idx   = '0;
        w_free_found  = 1'b0;
        w_free_idx    = '0;
        w_any_held    = 1'b0;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            if (!w_match_found && r_slot_key[i] == r_key) begin
                w_match_found = 1'b1;
                w_match_idx   = VW'(i);
            end
            if (!w_free_found && r_slot_key[i] == KEY_FREE) begin
                w_free_found = 1'b1;
                w_free_idx   = VW'(i);
            end
            if (r_slot_key[i] != KEY_FREE) begin
                w_any_held = 1'b1;
            end
        end
    end

    assign w_note_on_go = !w_is_off && (r_key[6:0] >= KEY_LOWEST) && w_free_found;

    // ---- round-robin: next held slot after the current voice -----------------
    assign w_elapsed = r_ts - r_last;
    assign w_cur_eff = (IW'(r_cur) >= IW'(VOICE_COUNT)) ? '0 : r_cur;

    always_comb begin
        logic          found;
        logic [IW-1:0] idx;
        found      = 1'b0;
        w_next_idx = w_cur_eff;
        for (int i = 1; i <= VOICE_COUNT; i++) begin
            idx = IW'(w_cur_eff) + IW'(i);
            if (idx >= IW'(VOICE_COUNT)) begin
                idx = idx - IW'(VOICE_COUNT);
            end
            if (!found && r_slot_key[idx[VW-1:0]] != KEY_FREE) begin
                found      = 1'b1;
                w_next_idx = idx[VW-1:0];
            end
        end
    end

    // ---- sequencer -----------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_slot_key  = r_slot_key;
        n_slot_div  = r_slot_div;
        n_cur       = r_cur;
        n_last      = r_last;
        n_slot_sel  = r_slot_sel;
        n_res_acc   = r_res_acc;
        n_res_act   = r_res_act;
        n_res_div   = r_res_div;
        n_out_valid = r_out_valid;
        n_out_acc   = r_out_acc;
        n_out_act   = r_out_act;
        n_out_div   = r_out_div;

        w_pitch_req.start = 1'b0;
        w_pitch_req.key   = r_key[6:0];

        // drain the output register
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_acc = 1'b1;
                n_res_act = ACT_NONE;
                n_res_div = '0;
                n_state   = S_OUT;
                if (r_op) begin
                    if (!w_any_held) begin
                        // nothing held: silence and rewind
                        n_cur     = '0;
                        n_res_act = ACT_SILENCE;
                    end else if ({16'b0, r_sweep} <= w_elapsed) begin
                        n_last    = r_ts;
                        n_res_act = ACT_BEEP;
                        n_res_div = r_slot_div[w_cur_eff];
                        n_cur     = w_next_idx;
                    end
                end else if (!w_chan_skip && w_is_note) begin
                    if (w_bad_data) begin
                        n_res_acc = 1'b0;
                    end else if (w_is_off) begin
                        if (w_match_found) begin
                            n_slot_key[w_match_idx] = KEY_FREE;
                        end
                    end else if (r_key[6:0] < KEY_LOWEST) begin
                        n_res_acc = 1'b0;
                    end else if (w_note_on_go) begin
                        // claim the slot once the divisor is ready
                        w_pitch_req.start = 1'b1;
                        n_slot_sel        = w_free_idx;
                        n_state           = S_PITCH;
                    end
                end
            end
            S_PITCH: begin
                if (w_pitch_rsp.done) begin
                    n_slot_key[r_slot_sel] = r_key;
                    n_slot_div[r_slot_sel] = w_pitch_rsp.divisor;
                    n_state                = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_res_acc;
                    n_out_act   = r_res_act;
                    n_out_div   = r_res_div;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_last      <= '0;
            r_sweep     <= SWEEP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_slot_key[i] <= KEY_FREE;
                r_slot_div[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_slot_key  <= n_slot_key;
            r_slot_div  <= n_slot_div;
            if (i_cfg_wr_en) begin
                r_sweep <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_op     <= i_s_axis_tuser;
            r_status <= i_s_axis_tdata[7:0];
            r_key    <= i_s_axis_tdata[15:8];
            r_vel    <= i_s_axis_tdata[23:16];
            r_ts     <= i_s_axis_tdata[55:24];
        end
        r_slot_sel <= n_slot_sel;
        r_res_acc  <= n_res_acc;
        r_res_act  <= n_res_act;
        r_res_div  <= n_res_div;
        r_out_acc  <= n_out_acc;
        r_out_act  <= n_out_act;
        r_out_div  <= n_out_div;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_div;
    assign o_m_axis_tuser  = {r_out_act, r_out_acc};

    // ---- pitch sequencer and shared divider ------------------------------------
    mva_pitch u_pitch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_pitch_req),
        .o_rsp     (w_pitch_rsp),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp)
    );

    mva_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---- assertions ------------------------------------------------------------
    `MVA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_s_fire, !o_s_axis_tready, "input ready right after accept")
    `MVA_ASSERT_NOW(a_voice_in_range, i_clk, i_rst_n, 1'b1, IW'(r_cur) < IW'(VOICE_COUNT), "current voice out of range")
    `MVA_ASSERT_NOW(a_beep_accepted, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[2:1] == ACT_BEEP, o_m_axis_tuser[0], "beep without accepted flag")
    `MVA_ASSERT_NOW(a_pitch_done_in_wait, i_clk, i_rst_n, w_pitch_rsp.done, r_state == S_PITCH, "pitch result outside pitch wait")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: midi_voice_arpeggiator_core regression
// Streams MIDI events and timer ticks into the arpeggiator and checks each
// untyped result against a cycle-free model of the voice slots, the pitch
// divisors and the round-robin sweep. A short table covers the extremes and
// the reject / ignore paths. Random traffic follows under several sweep
// intervals, with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mva_pkg::*;

    localparam int NUM_VOICES     = 3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_RUN  = 185;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 80;

    // Semitone fractions m of the factor (1 + m/256), entry 0 in the low byte.
    localparam logic [95:0] SEMI_FRAC_TAB = {
        8'd227, 8'd200, 8'd175, 8'd150, 8'd128, 8'd106,
        8'd86,  8'd67,  8'd48,  8'd31,  8'd15,  8'd0
    };

    typedef struct packed {
        logic        accepted;
        logic [1:0]  action;
        logic [15:0] divisor;
    } t_speaker_result;

    typedef struct packed {
        logic            op;
        logic [7:0]      status;
        logic [7:0]      key;
        logic [7:0]      vel;
        logic [31:0]     ts;
        logic            typed;    // use the typed result instead of the model
        t_speaker_result want;
    } t_stim;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata  = '0;  // status, key, velocity, timestamp
    logic        i_s_axis_tuser  = 1'b0;  // op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;  // pit_divisor
    logic [2:0]  o_m_axis_tuser;  // accepted, speaker_action
    logic        i_cfg_wr_en     = 1'b0;
    logic [15:0] i_cfg_wr_data   = '0;

    midi_voice_arpeggiator_core #(
        .VOICE_COUNT(NUM_VOICES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Voice model state
    // ------------------------------------------------------------------------
    logic [7:0]  held_keys [NUM_VOICES];
    logic [15:0] voice_div [NUM_VOICES];
    int unsigned play_voice       = 0;
    logic [31:0] last_switch      = '0;
    logic [15:0] sweep_ticks_now  = SWEEP_RESET;

    t_speaker_result pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic [31:0] tick_clock     = '0;
    bit          calm           = 1'b0;  // no idling on either stream
    bit          holdoff_req    = 1'b0;

    // Side-band for typed rows; driven with the transaction so the monitor
    // sees the value that belongs to the accepted item.
    logic            row_typed = 1'b0;
    t_speaker_result row_want  = '0;

    initial begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            held_keys[v] = KEY_FREE;
            voice_div[v] = '0;
        end
    end

    // Timer divisor for one key: INPUT_RATE / freq, freq in u32f8 from A4.
    function automatic logic [15:0] pitch_divisor(input logic [7:0] key);
        logic [31:0] freq;
        logic [31:0] quot;
        int unsigned key_dist;
        logic [7:0]  frac;
        if (key > {1'b0, KEY_A4}) begin
            key_dist = key - KEY_A4;
            frac = SEMI_FRAC_TAB[(key_dist % 12) * 8 +: 8];
            freq = 32'(FREQ_A4) << (key_dist / 12);
            freq = freq * (32'd256 + {24'd0, frac});
        end else begin
            key_dist = KEY_A4 - key;
            frac = SEMI_FRAC_TAB[(key_dist % 12) * 8 +: 8];
            freq = 32'(FREQ_A4) << 16;
            freq = freq >> (key_dist / 12);
            freq = freq / (32'd256 + {24'd0, frac});
        end
        if (freq == 0)
            return DIVISOR_MAX;
        quot = INPUT_RATE / freq;
        return (quot > 32'd65535) ? DIVISOR_MAX : quot[15:0];
    endfunction

    // Apply one accepted transaction to the voice model and return its result.
    function automatic t_speaker_result speaker_response(
        input logic op, input logic [7:0] status, input logic [7:0] key,
        input logic [7:0] vel, input logic [31:0] ts);
        t_speaker_result res;
        logic [3:0]      chan;
        logic [3:0]      kind;
        int              slot;
        bit              any_held;
        res      = '{1'b1, ACT_NONE, 16'd0};
        chan     = status[3:0];
        kind     = status[7:4];
        slot     = -1;
        any_held = 1'b0;
        if (!op) begin
            if (kind == TYPE_SYSTEM)
                chan = 4'd0;
            if (chan >= NUM_VOICES || chan == DRUM_CHANNEL)
                return res;
            if (kind != TYPE_NOTE_OFF && kind != TYPE_NOTE_ON)
                return res;
            if (key > 8'd127 || vel > 8'd127) begin
                res.accepted = 1'b0;
                return res;
            end
            if (kind == TYPE_NOTE_OFF || vel == 8'd0) begin
                // Release the first slot holding this key, if any.
                for (int v = NUM_VOICES - 1; v >= 0; v--)
                    if (held_keys[v] == key)
                        slot = v;
                if (slot >= 0)
                    held_keys[slot] = KEY_FREE;
                return res;
            end
            if (key < {1'b0, KEY_LOWEST}) begin
                res.accepted = 1'b0;
                return res;
            end
            for (int v = NUM_VOICES - 1; v >= 0; v--)
                if (held_keys[v] == KEY_FREE)
                    slot = v;
            if (slot >= 0) begin
                held_keys[slot] = key;
                voice_div[slot] = pitch_divisor(key);
            end
            return res;
        end

        for (int v = 0; v < NUM_VOICES; v++)
            if (held_keys[v] != KEY_FREE)
                any_held = 1'b1;
        if (!any_held) begin
            play_voice = 0;
            res.action = ACT_SILENCE;
            return res;
        end
        if ({16'd0, sweep_ticks_now} > ts - last_switch)
            return res;
        // Emit the current voice, even when it was released since the last
        // switch, then advance to the next held slot.
        last_switch = ts;
        if (play_voice >= NUM_VOICES)
            play_voice = 0;
        res.action  = ACT_BEEP;
        res.divisor = voice_div[play_voice];
        do
            play_voice = (play_voice + 1) % NUM_VOICES;
        while (held_keys[play_voice] == KEY_FREE);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: check results first, then predict the accepted input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_speaker_result got;
        t_speaker_result want;
        t_speaker_result calc;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{o_m_axis_tuser[0], o_m_axis_tuser[2:1], o_m_axis_tdata};
                if (pending_results.size() == 0) begin
                    $error("result with nothing outstanding: accepted %0d action %0d div %0d",
                           got.accepted, got.action, got.divisor);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, got.accepted);
                        mismatch_count++;
                    end
                    if (got.action !== want.action) begin
                        $error("speaker_action: expected %0d, actual %0d",
                               want.action, got.action);
                        mismatch_count++;
                    end
                    if (got.divisor !== want.divisor) begin
                        $error("pit_divisor: expected %0d, actual %0d",
                               want.divisor, got.divisor);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                calc = speaker_response(i_s_axis_tuser, i_s_axis_tdata[7:0],
                                        i_s_axis_tdata[15:8], i_s_axis_tdata[23:16],
                                        i_s_axis_tdata[55:24]);
                pending_results.push_back(row_typed ? row_want : calc);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int holdoff_left;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                for (holdoff_left = HOLDOFF_CYCLES; holdoff_left > 0; holdoff_left--)
                    @(posedge i_clk);
            end else begin
                i_m_axis_tready <= calm || ($urandom_range(99) >= 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one transaction, idling first now and then; return at the edge
    // that accepts it.
    task automatic send_item(input t_stim s);
        if (!calm && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= s.op;
        i_s_axis_tdata  <= {s.ts, s.vel, s.key, s.status};
        row_typed       <= s.typed;
        row_want        <= s.want;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
    endtask

    // Drop valid and hold until every outstanding result has been checked.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_sweep(input logic [15:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sweep_ticks_now = value;
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed traffic: ticks on an advancing clock, note-ons on
    // live channels, releases of held keys; the rest is noise.
    function automatic t_stim draw_event();
        t_stim      s;
        int         pick;
        int         idx;
        logic [3:0] chan;
        s      = '0;
        pick   = $urandom_range(99);
        chan   = 4'($urandom_range(NUM_VOICES - 1));
        idx    = $urandom_range(NUM_VOICES - 1);
        s.ts   = $urandom;
        if (pick < 40) begin
            s.op     = 1'b1;
            s.status = 8'($urandom);
            s.key    = 8'($urandom);
            s.vel    = 8'($urandom);
            if ($urandom_range(19) == 0)
                tick_clock = $urandom;
            else
                tick_clock += $urandom_range(0, 2 * int'(sweep_ticks_now) + 4);
            s.ts = tick_clock;
        end else if (pick < 65) begin
            s.status = {TYPE_NOTE_ON, chan};
            s.key    = ($urandom_range(3) == 0) ? 8'($urandom_range(60, 63))
                                                : 8'($urandom_range(14, 127));
            s.vel    = 8'($urandom_range(1, 127));
        end else if (pick < 85) begin
            s.key = (held_keys[idx] != KEY_FREE) ? held_keys[idx]
                                                 : 8'($urandom_range(14, 127));
            if ($urandom_range(3) == 0) begin
                s.status = {TYPE_NOTE_ON, chan};
                s.vel    = 8'd0;
            end else begin
                s.status = {TYPE_NOTE_OFF, chan};
                s.vel    = 8'($urandom_range(127));
            end
        end else begin
            case ($urandom_range(2))
                0: begin
                    s.status = 8'($urandom);
                    s.key    = 8'($urandom);
                    s.vel    = 8'($urandom);
                end
                1: begin
                    s.status = {TYPE_NOTE_ON, chan};
                    s.key    = 8'($urandom_range(13));
                    s.vel    = 8'($urandom_range(1, 127));
                end
                default: begin
                    s.status = {($urandom_range(1) == 0) ? TYPE_NOTE_ON : TYPE_NOTE_OFF, chan};
                    s.key    = 8'($urandom);
                    s.vel    = 8'($urandom);
                end
            endcase
        end
        return s;
    endfunction

    t_stim stim_rows [25];

    initial begin : main_seq
        logic [15:0] sweep_plan [5];
        // Directed rows: op, status, key, velocity, timestamp, typed, result.
        stim_rows = '{
            // empty voices: silence
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1, '{1'b1, ACT_SILENCE, 16'd0}},
            // fill all three slots: A4, top key, lowest key
            '{1'b0, 8'h90, 8'd69,  8'd127, 32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h91, 8'd127, 8'd1,   32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h92, 8'd14,  8'd127, 32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            // no free slot: dropped but accepted
            '{1'b0, 8'h90, 8'd60,  8'd64,  32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            // rejects: key below the lowest, key or velocity out of range
            '{1'b0, 8'h90, 8'd13,  8'd100, 32'h0, 1'b1, '{1'b0, ACT_NONE, 16'd0}},
            '{1'b0, 8'h91, 8'd128, 8'd10,  32'h0, 1'b1, '{1'b0, ACT_NONE, 16'd0}},
            '{1'b0, 8'h80, 8'd200, 8'd0,   32'h0, 1'b1, '{1'b0, ACT_NONE, 16'd0}},
            '{1'b0, 8'h92, 8'd60,  8'd128, 32'h0, 1'b1, '{1'b0, ACT_NONE, 16'd0}},
            // ignored: system status, high channel, drum channel, other type
            '{1'b0, 8'hF0, 8'd255, 8'd255, 32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h93, 8'd60,  8'd64,  32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h99, 8'd60,  8'd64,  32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'hB0, 8'd7,   8'd100, 32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            // sweep interval not yet elapsed
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'd15, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            // elapsed exactly, then across the wrap of the timestamp
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'd16,         1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF,  1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'h0000_0005,  1'b1, '{1'b1, ACT_NONE, 16'd0}},
            // note-off of a held key, of a key not held, note-on with velocity 0
            '{1'b0, 8'h81, 8'd127, 8'd0,  32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h80, 8'd50,  8'd64, 32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h92, 8'd14,  8'd0,  32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            // current voice was released: its stale divisor still plays once
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'h30, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b0, 8'h80, 8'd69,  8'd0,  32'h0, 1'b0, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b1, 8'h00, 8'h00, 8'h00, 32'h40, 1'b1, '{1'b1, ACT_SILENCE, 16'd0}},
            // system status with channel bits set; tick with junk in the event fields
            '{1'b0, 8'hFF, 8'h00, 8'h00, 32'h0, 1'b1, '{1'b1, ACT_NONE, 16'd0}},
            '{1'b1, 8'h90, 8'hFF, 8'hFF, 32'h50, 1'b1, '{1'b1, ACT_SILENCE, 16'd0}}
        };
        sweep_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 64)), 16'd3};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r])
            send_item(stim_rows[r]);

        // Random traffic, one sweep setting per run.
        for (int run = 0; run < 5; run++) begin
            write_sweep(sweep_plan[run]);
            if (run == 1)
                tick_clock = 32'hFFFF_0000;  // cross the wrap early
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                calm = (run == 0 && n < 120);
                if (run == 2 && n == 40)
                    holdoff_req = 1'b1;  // let the block back up and stall
                send_item(draw_event());
            end
            calm = 1'b0;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
